// ----- rtl/core/oled_region_refresh_sequencer_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion helpers for the OLED region refresh sequencer core
// ---------------------------------------------------------------------------
`ifndef OLED_REGION_REFRESH_SEQUENCER_CORE_DEFINES_SVH
`define OLED_REGION_REFRESH_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define ORRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ORRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/oledrs_pkg.sv -----
// ---------------------------------------------------------------------------
// oledrs_pkg
// Shared types, constants and the init command table of the OLED region
// refresh sequencer.
// ---------------------------------------------------------------------------
package oledrs_pkg;

  // Panel geometry
  localparam int PAGES    = 8;
  localparam int COLS     = 128;
  localparam int PAGE_W   = $clog2(PAGES);
  localparam int COL_W    = $clog2(COLS);
  localparam int PCNT_W   = $clog2(PAGES + 1);
  localparam int CCNT_W   = $clog2(COLS + 1);
  localparam int ADDR_W   = PAGE_W + COL_W;
  localparam int FB_DEPTH = 1 << ADDR_W;

  // Clipping sums: start plus count before clamping
  localparam int PSUM_W   = 5;
  localparam int CSUM_W   = 9;

  // Init sequence
  localparam int INIT_LEN = 28;
  localparam int STEP_W   = 5;

  // Refresh row steps
  localparam logic [STEP_W-1:0] STEP_PAGE    = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_COL_LO  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_COL_HI  = STEP_W'(2);

  // Byte constants
  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] BORDER_BYTE   = 8'hff;
  localparam logic [7:0] MASK_SINGLE   = 8'h81;
  localparam logic [7:0] MASK_TOP      = 8'h01;
  localparam logic [7:0] MASK_BOTTOM   = 8'h80;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_PAGE_START = 3'd0,
    REG_PAGE_COUNT = 3'd1,
    REG_COL_START  = 3'd2,
    REG_COL_COUNT  = 3'd3,
    REG_MARGIN_ON  = 3'd4,
    REG_INVERT     = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_REFRESH = 4'b0010,
    MODE_INIT    = 4'b0100,
    MODE_CLEAR   = 4'b1000
  } mode_t;

  // Configuration registers
  typedef struct packed {
    logic [2:0] page_start;
    logic [3:0] page_count;
    logic [6:0] col_start;
    logic [7:0] col_count;
    logic       margin_on;
    logic       invert;
  } cfg_t;

  // One output beat as described by the sequencer; the final byte is built
  // once the buffer read returns.
  typedef struct packed {
    logic       valid;
    logic       is_data;
    logic       use_ram;
    logic [7:0] const_byte;
    logic       inv;
    logic [7:0] mask;
    logic       last;
  } beat_t;

  // Fixed panel init commands
  function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'hae;
      5'd1:    b = 8'h00;
      5'd2:    b = 8'h10;
      5'd3:    b = 8'h40;
      5'd4:    b = 8'h81;
      5'd5:    b = 8'hcf;
      5'd6:    b = 8'ha1;
      5'd7:    b = 8'hc8;
      5'd8:    b = 8'ha6;
      5'd9:    b = 8'ha8;
      5'd10:   b = 8'h3f;
      5'd11:   b = 8'hd3;
      5'd12:   b = 8'h00;
      5'd13:   b = 8'hd5;
      5'd14:   b = 8'h80;
      5'd15:   b = 8'hd9;
      5'd16:   b = 8'hf1;
      5'd17:   b = 8'hda;
      5'd18:   b = 8'h12;
      5'd19:   b = 8'hdb;
      5'd20:   b = 8'h40;
      5'd21:   b = 8'h20;
      5'd22:   b = 8'h02;
      5'd23:   b = 8'h8d;
      5'd24:   b = 8'h14;
      5'd25:   b = 8'ha4;
      5'd26:   b = 8'ha6;
      5'd27:   b = 8'haf;
      default: b = 8'hae;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/oledrs_ram.sv -----
// ---------------------------------------------------------------------------
// oledrs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module oledrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/oledrs_seq.sv -----
// ---------------------------------------------------------------------------
// oledrs_seq
// Sequencer state: mode, page/column/step counters and the latched region.
// Describes the beat for each accepted tick and drives the buffer read
// address for it.
// ---------------------------------------------------------------------------
module oledrs_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [1:0]                    op,
  input  oledrs_pkg::cfg_t              cfg,
  output logic [oledrs_pkg::ADDR_W-1:0] rd_addr,
  output oledrs_pkg::beat_t             beat
);

  oledrs_pkg::mode_t                 mode, mode_next;
  logic [oledrs_pkg::PAGE_W-1:0]     cur_page, cur_page_next;
  logic [oledrs_pkg::COL_W-1:0]      cur_col, cur_col_next;
  logic [oledrs_pkg::STEP_W-1:0]     step, step_next;
  logic [oledrs_pkg::PAGE_W-1:0]     lat_ps, lat_ps_next;
  logic [oledrs_pkg::PCNT_W-1:0]     lat_pe, lat_pe_next;
  logic [oledrs_pkg::COL_W-1:0]      lat_cs, lat_cs_next;
  logic [oledrs_pkg::CCNT_W-1:0]     lat_ce, lat_ce_next;
  logic                              lat_margin, lat_margin_next;
  logic                              lat_inv, lat_inv_next;

  // Clipped region from the live registers
  logic [oledrs_pkg::PSUM_W-1:0]     psum;
  logic [oledrs_pkg::CSUM_W-1:0]     csum;
  logic [oledrs_pkg::PCNT_W-1:0]     reg_pe;
  logic [oledrs_pkg::CCNT_W-1:0]     reg_ce;
  logic [oledrs_pkg::PAGE_W-1:0]     reg_ps;
  logic [oledrs_pkg::COL_W-1:0]      reg_cs;
  logic                              region_ok;

  // Row counters one ahead
  logic [oledrs_pkg::CCNT_W-1:0]     col_inc;
  logic [oledrs_pkg::PCNT_W-1:0]     page_inc;
  logic [oledrs_pkg::PCNT_W-1:0]     ps_inc;

  assign reg_ps = cfg.page_start[oledrs_pkg::PAGE_W-1:0];
  assign reg_cs = cfg.col_start[oledrs_pkg::COL_W-1:0];
  assign psum   = oledrs_pkg::PSUM_W'(cfg.page_start) + oledrs_pkg::PSUM_W'(cfg.page_count);
  assign csum   = oledrs_pkg::CSUM_W'(cfg.col_start) + oledrs_pkg::CSUM_W'(cfg.col_count);
  assign reg_pe = (psum > oledrs_pkg::PSUM_W'(oledrs_pkg::PAGES))
                  ? oledrs_pkg::PCNT_W'(oledrs_pkg::PAGES)
                  : oledrs_pkg::PCNT_W'(psum);
  assign reg_ce = (csum > oledrs_pkg::CSUM_W'(oledrs_pkg::COLS))
                  ? oledrs_pkg::CCNT_W'(oledrs_pkg::COLS)
                  : oledrs_pkg::CCNT_W'(csum);
  assign region_ok = (oledrs_pkg::PCNT_W'(cfg.page_start) < reg_pe) &&
                     (oledrs_pkg::CCNT_W'(cfg.col_start) < reg_ce);

  assign col_inc  = oledrs_pkg::CCNT_W'(cur_col) + oledrs_pkg::CCNT_W'(1);
  assign page_inc = oledrs_pkg::PCNT_W'(cur_page) + oledrs_pkg::PCNT_W'(1);
  assign ps_inc   = oledrs_pkg::PCNT_W'(lat_ps) + oledrs_pkg::PCNT_W'(1);

  // Buffer read address for a data beat
  assign rd_addr = {cur_page, cur_col};

  // Next state and beat description
  always_comb begin
    mode_next       = mode;
    cur_page_next   = cur_page;
    cur_col_next    = cur_col;
    step_next       = step;
    lat_ps_next     = lat_ps;
    lat_pe_next     = lat_pe;
    lat_cs_next     = lat_cs;
    lat_ce_next     = lat_ce;
    lat_margin_next = lat_margin;
    lat_inv_next    = lat_inv;
    beat            = '0;

    if (accept) begin
      case (oledrs_pkg::op_t'(op))
        oledrs_pkg::OP_REFRESH: begin
          if (mode == oledrs_pkg::MODE_IDLE && region_ok) begin
            mode_next       = oledrs_pkg::MODE_REFRESH;
            lat_ps_next     = reg_ps;
            lat_pe_next     = reg_pe;
            lat_cs_next     = reg_cs;
            lat_ce_next     = reg_ce;
            lat_margin_next = cfg.margin_on;
            lat_inv_next    = cfg.invert;
            cur_page_next   = reg_ps;
            cur_col_next    = reg_cs;
            step_next       = '0;
          end
        end
        oledrs_pkg::OP_INIT: begin
          if (mode == oledrs_pkg::MODE_IDLE) begin
            mode_next = oledrs_pkg::MODE_INIT;
            step_next = '0;
          end
        end
        oledrs_pkg::OP_TICK: begin
          unique case (mode)
            oledrs_pkg::MODE_IDLE: begin
            end
            oledrs_pkg::MODE_INIT: begin
              beat.valid      = 1'b1;
              beat.const_byte = oledrs_pkg::init_cmd(step);
              step_next       = step + oledrs_pkg::STEP_W'(1);
              if (step == oledrs_pkg::STEP_W'(oledrs_pkg::INIT_LEN - 1)) begin
                // Init done: sweep the whole panel with zeros
                mode_next       = oledrs_pkg::MODE_CLEAR;
                lat_ps_next     = '0;
                lat_pe_next     = oledrs_pkg::PCNT_W'(oledrs_pkg::PAGES);
                lat_cs_next     = '0;
                lat_ce_next     = oledrs_pkg::CCNT_W'(oledrs_pkg::COLS);
                lat_margin_next = 1'b0;
                lat_inv_next    = 1'b0;
                cur_page_next   = '0;
                cur_col_next    = '0;
                step_next       = '0;
              end
            end
            oledrs_pkg::MODE_REFRESH, oledrs_pkg::MODE_CLEAR: begin
              beat.valid = 1'b1;
              case (step)
                oledrs_pkg::STEP_PAGE: begin
                  beat.const_byte = oledrs_pkg::CMD_PAGE_BASE + 8'(cur_page);
                  step_next       = oledrs_pkg::STEP_COL_LO;
                end
                oledrs_pkg::STEP_COL_LO: begin
                  beat.const_byte = {4'h0, lat_cs[3:0]};
                  step_next       = oledrs_pkg::STEP_COL_HI;
                end
                oledrs_pkg::STEP_COL_HI: begin
                  beat.const_byte = oledrs_pkg::CMD_COL_HI | 8'(lat_cs >> 4);
                  step_next       = oledrs_pkg::STEP_COL_HI + oledrs_pkg::STEP_W'(1);
                  cur_col_next    = lat_cs;
                end
                default: begin
                  beat.is_data = 1'b1;
                  if (mode == oledrs_pkg::MODE_CLEAR) begin
                    beat.const_byte = 8'h00;
                  end else if (lat_margin && (cur_col == lat_cs || col_inc == lat_ce)) begin
                    // Left or right border column
                    beat.const_byte = oledrs_pkg::BORDER_BYTE;
                  end else begin
                    beat.use_ram = 1'b1;
                    beat.inv     = lat_inv;
                    if (lat_margin) begin
                      if (ps_inc == lat_pe) begin
                        beat.mask = oledrs_pkg::MASK_SINGLE;
                      end else if (cur_page == lat_ps) begin
                        beat.mask = oledrs_pkg::MASK_TOP;
                      end else if (page_inc == lat_pe) begin
                        beat.mask = oledrs_pkg::MASK_BOTTOM;
                      end
                    end
                  end
                  cur_col_next = oledrs_pkg::COL_W'(col_inc);
                  // End of row
                  if (col_inc >= lat_ce) begin
                    cur_page_next = oledrs_pkg::PAGE_W'(page_inc);
                    cur_col_next  = lat_cs;
                    step_next     = oledrs_pkg::STEP_PAGE;
                    if (page_inc >= lat_pe) begin
                      beat.last     = 1'b1;
                      mode_next     = oledrs_pkg::MODE_IDLE;
                      cur_page_next = '0;
                      cur_col_next  = '0;
                    end
                  end
                end
              endcase
            end
            default: begin
              mode_next = oledrs_pkg::MODE_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= oledrs_pkg::MODE_IDLE;
      cur_page   <= '0;
      cur_col    <= '0;
      step       <= '0;
      lat_ps     <= '0;
      lat_pe     <= '0;
      lat_cs     <= '0;
      lat_ce     <= '0;
      lat_margin <= 1'b0;
      lat_inv    <= 1'b0;
    end else begin
      mode       <= mode_next;
      cur_page   <= cur_page_next;
      cur_col    <= cur_col_next;
      step       <= step_next;
      lat_ps     <= lat_ps_next;
      lat_pe     <= lat_pe_next;
      lat_cs     <= lat_cs_next;
      lat_ce     <= lat_ce_next;
      lat_margin <= lat_margin_next;
      lat_inv    <= lat_inv_next;
    end
  end

endmodule

// ----- rtl/core/oled_region_refresh_sequencer_core.sv -----
// ---------------------------------------------------------------------------
// oled_region_refresh_sequencer_core
// Page-mode OLED refresh sequencer: frame buffer in a RAM, region refresh
// and init/clear sequences, one panel byte out per tick.
// ---------------------------------------------------------------------------
//   channel | signals                                  | handshake
//   --------+------------------------------------------+-----------------
//   in      | op, page_sel, col_sel, pixel_byte        | in_valid/in_stall
//   out     | is_data, out_byte, last                  | out_valid/out_stall
//   cfg     | cfg_index, cfg_data                      | cfg_valid/cfg_ready
//
// One beat accepted per cycle while in_stall is low; a tick's byte passes
// through the read stage (buffer read), then the output register.
// The 1024x8 buffer RAM has one write and one read port.
// Reset is synchronous; the buffer has no clearing pass and holds garbage
// until written. cfg_ready is always high.
// in_stall rises only when both the read stage and the output register are
// full and out_stall is high.
// ---------------------------------------------------------------------------
`include "oled_region_refresh_sequencer_core_defines.svh"

module oled_region_refresh_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  // Item input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [2:0] page_sel,
  input  logic [6:0] col_sel,
  input  logic [7:0] pixel_byte,
  // Result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_data,
  output logic [7:0] out_byte,
  output logic       last,
  // Configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  oledrs_pkg::cfg_t                 cfg;
  oledrs_pkg::beat_t                beat;
  oledrs_pkg::beat_t                s1;
  logic                             s1_valid;
  logic                             s1_move;
  logic                             in_accept;
  logic [oledrs_pkg::ADDR_W-1:0]    rd_addr;
  logic [oledrs_pkg::ADDR_W-1:0]    wr_addr;
  logic                             wr_en;
  logic [7:0]                       rd_data;
  logic [7:0]                       s1_byte;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign s1_move   = s1_valid && (!out_valid || !out_stall);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_start <= 3'd0;
      cfg.page_count <= 4'd8;
      cfg.col_start  <= 7'd0;
      cfg.col_count  <= 8'd128;
      cfg.margin_on  <= 1'b0;
      cfg.invert     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (oledrs_pkg::reg_idx_t'(cfg_index))
        oledrs_pkg::REG_PAGE_START: cfg.page_start <= cfg_data[2:0];
        oledrs_pkg::REG_PAGE_COUNT: cfg.page_count <= cfg_data[3:0];
        oledrs_pkg::REG_COL_START:  cfg.col_start  <= cfg_data[6:0];
        oledrs_pkg::REG_COL_COUNT:  cfg.col_count  <= cfg_data;
        oledrs_pkg::REG_MARGIN_ON:  cfg.margin_on  <= cfg_data[0];
        oledrs_pkg::REG_INVERT:     cfg.invert     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  oledrs_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .op      (op),
    .cfg     (cfg),
    .rd_addr (rd_addr),
    .beat    (beat)
  );

  // Buffer writes from op 1, dropped when the address is off the panel
  assign wr_addr = {page_sel[oledrs_pkg::PAGE_W-1:0], col_sel[oledrs_pkg::COL_W-1:0]};
  assign wr_en   = in_accept && (oledrs_pkg::op_t'(op) == oledrs_pkg::OP_WRITE) &&
                   (int'(page_sel) < oledrs_pkg::PAGES) &&
                   (int'(col_sel) < oledrs_pkg::COLS);

  oledrs_ram #(
    .WIDTH (8),
    .DEPTH (oledrs_pkg::FB_DEPTH)
  ) u_fb (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (pixel_byte),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read stage: beat waits here while the buffer read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= beat.valid;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1 <= beat;
    end
  end

  // Final byte: buffer data with invert and border mask, or a fixed byte
  assign s1_byte = s1.use_ram ? ((rd_data ^ {8{s1.inv}}) | s1.mask) : s1.const_byte;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      is_data  <= s1.is_data;
      out_byte <= s1_byte;
      last     <= s1.last;
    end
  end

  // Checks
  `ORRS_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && out_valid && out_stall, s1_valid && $stable(s1), "read stage lost a beat under output stall")
  `ORRS_ASSERT_NOW(a_last_is_data, clk, rst, out_valid && last, is_data, "final beat of a sequence is not a data byte")
  `ORRS_ASSERT_NOW(a_ram_beat_data, clk, rst, s1_valid && s1.use_ram, s1.is_data && !s1.last || s1.is_data, "buffer byte tagged as command")

endmodule
